[design/kcp_pkg.sv]
// shared types and constants of the keyboard command processor
package kcp_pkg;

  localparam logic [1:0] REQ_CMD     = 2'd0;
  localparam logic [1:0] REQ_PRESS   = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  localparam logic [2:0] CMD_RPT_DELAY = 3'd0;
  localparam logic [2:0] CMD_RPT_RATE  = 3'd1;
  localparam logic [2:0] CMD_LED_SET   = 3'd2;
  localparam logic [2:0] CMD_LED_READ  = 3'd3;
  localparam logic [2:0] CMD_SW_READ   = 3'd4;
  localparam logic [2:0] CMD_RPT_EN    = 3'd5;
  localparam logic [2:0] CMD_KEY_EN    = 3'd6;
  localparam logic [2:0] CMD_RESET     = 3'd7;

  localparam logic [7:0] KEY_SHIFT = 8'h10;
  localparam logic [7:0] KEY_CTRL  = 8'h11;
  localparam logic [7:0] KEY_GRAPH = 8'h12;

  localparam logic [7:0] BRK_SHIFT = 8'h86;
  localparam logic [7:0] BRK_CTRL  = 8'h8a;
  localparam logic [7:0] BRK_GRAPH = 8'h8c;
  localparam logic [7:0] DIAG_BYTE = 8'h00;

  localparam logic [3:0] LED_PREFIX = 4'b1100;
  localparam logic [3:0] SW_PREFIX  = 4'b1000;

  localparam logic [2:0] IDX_SHIFT = 3'd3;
  localparam logic [2:0] IDX_CTRL  = 3'd5;
  localparam logic [2:0] IDX_GRAPH = 3'd6;
  localparam logic [2:0] IDX_LAST  = 3'd7;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    JOB_BYTE,
    JOB_LEDS,
    JOB_SWITCH
  } job_op_t;

  typedef struct packed {
    job_op_t    op;
    logic [7:0] data;
    logic       clr;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

[design/kcp_ifs.sv]
// item channel interfaces of the keyboard command processor
interface kcp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] value;
  logic [7:0] make_code;

  modport source (output valid, output req_type, output value, output make_code,
                  input ready);
  modport sink (input valid, input req_type, input value, input make_code,
                output ready);
endinterface

interface kcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       clear_first;
  logic       last;

  modport source (output valid, output out_byte, output clear_first, output last,
                  input ready);
  modport sink (input valid, input out_byte, input clear_first, input last,
                output ready);
endinterface

[design/kcp_front.sv]
// front end: accepts items, keeps keyboard state, queues output jobs
module kcp_front (
  input  logic             clk,
  input  logic             rst_n,
  kcp_in_if.sink           in_ch,
  input  kcp_pkg::q_stat_t q_stat,
  output logic             push,
  output kcp_pkg::job_t    push_job
);

  logic [7:0] led_r, led_nxt;
  logic       en_r, en_nxt;
  logic       rpt_r, rpt_nxt;
  logic [2:0] mod_r, mod_nxt;
  logic [2:0] mb;
  logic       acc;

  assign in_ch.ready = !q_stat.full;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    unique case (in_ch.value)
      kcp_pkg::KEY_SHIFT: mb = 3'b001;
      kcp_pkg::KEY_CTRL:  mb = 3'b010;
      kcp_pkg::KEY_GRAPH: mb = 3'b100;
      default:            mb = 3'b000;
    endcase
  end

  always_comb begin
    led_nxt  = led_r;
    en_nxt   = en_r;
    rpt_nxt  = rpt_r;
    mod_nxt  = mod_r;
    push     = 1'b0;
    push_job = '{op: kcp_pkg::JOB_BYTE, data: 8'h00, clr: 1'b0};
    if (acc) begin
      case (in_ch.req_type)
        kcp_pkg::REQ_CMD: begin
          unique case (in_ch.value[7:5])
            kcp_pkg::CMD_RPT_DELAY, kcp_pkg::CMD_RPT_RATE: ;
            kcp_pkg::CMD_LED_SET: led_nxt[in_ch.value[3:1]] = in_ch.value[0];
            kcp_pkg::CMD_LED_READ: begin
              push     = 1'b1;
              push_job = '{op: kcp_pkg::JOB_LEDS, data: led_r, clr: 1'b1};
            end
            kcp_pkg::CMD_SW_READ: begin
              push     = 1'b1;
              push_job = '{op: kcp_pkg::JOB_SWITCH, data: {5'b0, mod_r}, clr: 1'b1};
            end
            kcp_pkg::CMD_RPT_EN: rpt_nxt = in_ch.value[0];
            kcp_pkg::CMD_KEY_EN: en_nxt = in_ch.value[0];
            kcp_pkg::CMD_RESET: begin
              led_nxt = 8'h00;
              en_nxt  = 1'b1;
              rpt_nxt = 1'b1;
              if (!in_ch.value[0]) begin
                push     = 1'b1;
                push_job = '{op: kcp_pkg::JOB_BYTE, data: kcp_pkg::DIAG_BYTE, clr: 1'b1};
              end
            end
            default: ;
          endcase
        end
        kcp_pkg::REQ_PRESS: begin
          mod_nxt = mod_r | mb;
          if (en_r && (in_ch.make_code != 8'h00)) begin
            push     = 1'b1;
            push_job = '{op: kcp_pkg::JOB_BYTE, data: in_ch.make_code, clr: 1'b0};
          end
        end
        kcp_pkg::REQ_RELEASE: begin
          mod_nxt = mod_r & ~mb;
          if (en_r && (mb != 3'b000)) begin
            push = 1'b1;
            unique case (mb)
              3'b001:  push_job.data = kcp_pkg::BRK_SHIFT;
              3'b010:  push_job.data = kcp_pkg::BRK_CTRL;
              default: push_job.data = kcp_pkg::BRK_GRAPH;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r <= 8'h00;
      en_r  <= 1'b1;
      rpt_r <= 1'b1;
      mod_r <= 3'b000;
    end else begin
      led_r <= led_nxt;
      en_r  <= en_nxt;
      rpt_r <= rpt_nxt;
      mod_r <= mod_nxt;
    end
  end

endmodule

[design/kcp_queue.sv]
// short job queue between front and back end
module kcp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kcp_pkg::job_t     push_job,
  input  logic              pop,
  output kcp_pkg::job_t     pop_job,
  output kcp_pkg::q_stat_t  q_stat
);

  kcp_pkg::job_t              mem_r [kcp_pkg::QDEPTH];
  logic [kcp_pkg::QAW-1:0]    wr_r, wr_nxt;
  logic [kcp_pkg::QAW-1:0]    rd_r, rd_nxt;
  logic [kcp_pkg::QCW-1:0]    cnt_r, cnt_nxt;

  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == kcp_pkg::QCW'(kcp_pkg::QDEPTH));
  assign pop_job      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/kcp_back.sv]
// back end: expands queued jobs into output bytes behind an output register
module kcp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  kcp_pkg::q_stat_t q_stat,
  input  kcp_pkg::job_t    pop_job,
  output logic             pop,
  kcp_out_if.source        out_ch
);

  kcp_pkg::job_t cur_r, cur_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          oc_r, oc_nxt;
  logic          ol_r, ol_nxt;
  logic          take;
  logic          fire;
  logic          done;
  logic          sw_bit;
  logic [7:0]    gen_byte;

  assign out_ch.valid       = ov_r;
  assign out_ch.out_byte    = ob_r;
  assign out_ch.clear_first = oc_r;
  assign out_ch.last        = ol_r;

  assign take = !ov_r || out_ch.ready;
  assign fire = cur_valid_r && take;
  assign done = fire && ((cur_r.op == kcp_pkg::JOB_BYTE) || (cnt_r == kcp_pkg::IDX_LAST));
  assign pop  = q_stat.valid && (!cur_valid_r || done);

  always_comb begin
    case (cnt_r)
      kcp_pkg::IDX_SHIFT: sw_bit = cur_r.data[0];
      kcp_pkg::IDX_CTRL:  sw_bit = cur_r.data[1];
      kcp_pkg::IDX_GRAPH: sw_bit = cur_r.data[2];
      default:            sw_bit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cur_r.op)
      kcp_pkg::JOB_LEDS:   gen_byte = {kcp_pkg::LED_PREFIX, cnt_r, cur_r.data[cnt_r]};
      kcp_pkg::JOB_SWITCH: gen_byte = {kcp_pkg::SW_PREFIX, cnt_r, sw_bit};
      default:             gen_byte = cur_r.data;
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    cnt_nxt       = cnt_r;
    ov_nxt        = ov_r;
    ob_nxt        = ob_r;
    oc_nxt        = oc_r;
    ol_nxt        = ol_r;
    if (fire) begin
      ov_nxt = 1'b1;
      ob_nxt = gen_byte;
      oc_nxt = cur_r.clr && (cnt_r == 3'd0);
      ol_nxt = done;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    if (pop) begin
      cur_nxt       = pop_job;
      cur_valid_nxt = 1'b1;
      cnt_nxt       = 3'd0;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (fire) begin
      cnt_nxt = cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ob_r  <= ob_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= 3'd0;
      ov_r        <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cnt_r       <= cnt_nxt;
      ov_r        <= ov_nxt;
    end
  end

endmodule

[design/keyboard_command_processor.sv]
// keyboard command processor top level
// an item's bytes pass the job queue, the current job register and the output register
// throughput: one output byte per cycle from the back end expander while host is ready;
// an input item per cycle while the 4-entry job queue has room, status reads 8 bytes each
// items that cause no byte are handled in the front end only
// reset: synchronous active-low, leds cleared, enable and repeat set, queue emptied
module keyboard_command_processor (
  input  logic      clk,
  input  logic      rst_n,
  kcp_in_if.sink    in_ch,
  kcp_out_if.source out_ch
);

  kcp_pkg::q_stat_t q_stat;
  kcp_pkg::job_t    push_job;
  kcp_pkg::job_t    pop_job;
  logic             push;
  logic             pop;

  kcp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  kcp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  kcp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_job (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

[test/testbench.sv]
// self-checking testbench of the keyboard command processor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int FROM_MODEL = -1;
  localparam int NO_REPLY   = 0;
  localparam int ONE_BYTE   = 1;

  localparam int N_DIRECTED       = 26;
  localparam int RANDOM_ITEMS     = 104;
  localparam int DRAIN_PAUSE_AT   = 40;
  localparam int CALM_FROM        = 84;
  localparam int LONG_HOLD_AT     = 70;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 10;
  localparam int CYCLE_LIMIT      = 200000;

  typedef struct packed {
    logic [7:0] code;
    logic       clr;
    logic       last;
  } host_byte_t;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] val;
    logic [7:0] mk;
    int         n_typed;
    logic [7:0] typed_code;
    logic       typed_clr;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  kcp_in_if  in_ch ();
  kcp_out_if out_ch ();

  keyboard_command_processor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // keyboard state as seen from the host side
  logic [7:0] led_flags     = '0;
  logic       keys_enabled  = 1'b1;
  logic       repeat_on     = 1'b1;
  logic [2:0] modifier_held = '0;

  host_byte_t reply_bytes[$];
  host_byte_t pending_bytes[$];

  int fail_count     = 0;
  int items_accepted = 0;
  int cycle_count    = 0;
  bit calm           = 1'b0;
  bit hold_done      = 1'b0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{kcp_pkg::REQ_CMD,     8'h60, 8'h00, FROM_MODEL, 8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'h80, 8'h00, FROM_MODEL, 8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'he0, 8'h00, ONE_BYTE,   kcp_pkg::DIAG_BYTE, 1'b1},
    '{kcp_pkg::REQ_CMD,     8'he1, 8'hff, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'h00, 8'h00, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'h3f, 8'h00, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'h4f, 8'h00, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'h41, 8'h00, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'h60, 8'h00, FROM_MODEL, 8'h00, 1'b0},
    '{kcp_pkg::REQ_PRESS,   kcp_pkg::KEY_SHIFT, 8'h00, NO_REPLY, 8'h00, 1'b0},
    '{kcp_pkg::REQ_PRESS,   kcp_pkg::KEY_CTRL,  8'hff, ONE_BYTE, 8'hff, 1'b0},
    '{kcp_pkg::REQ_PRESS,   kcp_pkg::KEY_GRAPH, 8'h01, ONE_BYTE, 8'h01, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'h80, 8'h00, FROM_MODEL, 8'h00, 1'b0},
    '{kcp_pkg::REQ_RELEASE, kcp_pkg::KEY_SHIFT, 8'h00, ONE_BYTE, kcp_pkg::BRK_SHIFT, 1'b0},
    '{kcp_pkg::REQ_RELEASE, 8'h55, 8'haa, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'ha0, 8'h00, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'hc0, 8'h00, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_PRESS,   8'hff, 8'hff, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_RELEASE, kcp_pkg::KEY_GRAPH, 8'h00, NO_REPLY, 8'h00, 1'b0},
    '{kcp_pkg::REQ_PRESS,   kcp_pkg::KEY_SHIFT, 8'h80, NO_REPLY, 8'h00, 1'b0},
    '{REQ_UNUSED,           8'hff, 8'hff, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'hc1, 8'h00, NO_REPLY,   8'h00, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'h80, 8'h00, FROM_MODEL, 8'h00, 1'b0},
    '{kcp_pkg::REQ_RELEASE, kcp_pkg::KEY_CTRL,  8'h00, ONE_BYTE, kcp_pkg::BRK_CTRL, 1'b0},
    '{kcp_pkg::REQ_RELEASE, kcp_pkg::KEY_GRAPH, 8'hff, ONE_BYTE, kcp_pkg::BRK_GRAPH, 1'b0},
    '{kcp_pkg::REQ_CMD,     8'ha1, 8'h00, NO_REPLY,   8'h00, 1'b0}
  };

  function automatic void add_reply(input logic [7:0] code, input logic clr);
    reply_bytes.push_back('{code, clr, 1'b0});
  endfunction

  function automatic void keyboard_reply(input logic [1:0] req, input logic [7:0] val,
                                         input logic [7:0] mk);
    logic [2:0] mod_mask;
    logic [7:0] code;
    mod_mask = (val == kcp_pkg::KEY_SHIFT) ? 3'b001 :
               (val == kcp_pkg::KEY_CTRL)  ? 3'b010 :
               (val == kcp_pkg::KEY_GRAPH) ? 3'b100 : 3'b000;
    reply_bytes.delete();
    case (req)
      kcp_pkg::REQ_CMD: begin
        case (val[7:5])
          kcp_pkg::CMD_LED_SET: led_flags[val[3:1]] = val[0];
          kcp_pkg::CMD_LED_READ: begin
            for (int i = 0; i < 8; i++)
              add_reply({kcp_pkg::LED_PREFIX, 3'(i), led_flags[i]}, i == 0);
          end
          kcp_pkg::CMD_SW_READ: begin
            for (int i = 0; i < 8; i++) begin
              code = {kcp_pkg::SW_PREFIX, 3'(i), 1'b0};
              if (i == kcp_pkg::IDX_SHIFT) code[0] = modifier_held[0];
              if (i == kcp_pkg::IDX_CTRL)  code[0] = modifier_held[1];
              if (i == kcp_pkg::IDX_GRAPH) code[0] = modifier_held[2];
              add_reply(code, i == 0);
            end
          end
          kcp_pkg::CMD_RPT_EN: repeat_on = val[0];
          kcp_pkg::CMD_KEY_EN: keys_enabled = val[0];
          kcp_pkg::CMD_RESET: begin
            led_flags    = '0;
            repeat_on    = 1'b1;
            keys_enabled = 1'b1;
            if (!val[0]) add_reply(kcp_pkg::DIAG_BYTE, 1'b1);
          end
          default: ;
        endcase
      end
      kcp_pkg::REQ_PRESS: begin
        modifier_held = modifier_held | mod_mask;
        if (keys_enabled && mk != 8'h00) add_reply(mk, 1'b0);
      end
      kcp_pkg::REQ_RELEASE: begin
        modifier_held = modifier_held & ~mod_mask;
        if (keys_enabled) begin
          if (mod_mask[0]) add_reply(kcp_pkg::BRK_SHIFT, 1'b0);
          else if (mod_mask[1]) add_reply(kcp_pkg::BRK_CTRL, 1'b0);
          else if (mod_mask[2]) add_reply(kcp_pkg::BRK_GRAPH, 1'b0);
        end
      end
      default: ;
    endcase
    if (reply_bytes.size() > 0) reply_bytes[reply_bytes.size() - 1].last = 1'b1;
  endfunction

  function automatic stim_row_t random_item();
    stim_row_t row;
    int pick;
    pick = $urandom_range(0, 99);
    row = '{kcp_pkg::REQ_CMD, 8'h00, 8'h00, FROM_MODEL, 8'h00, 1'b0};
    row.mk = 8'($urandom);
    if ($urandom_range(0, 4) < 2) row.val = 8'(kcp_pkg::KEY_SHIFT + $urandom_range(0, 2));
    else row.val = 8'($urandom);
    if (pick < 30) begin
      row.req = kcp_pkg::REQ_PRESS;
      if ($urandom_range(0, 7) == 0) row.mk = 8'h00;
    end else if (pick < 55) begin
      row.req = kcp_pkg::REQ_RELEASE;
    end else if (pick < 95) begin
      row.val = {3'($urandom_range(0, 7)), 5'($urandom)};
    end else begin
      row.req = REQ_UNUSED;
    end
    return row;
  endfunction

  task automatic offer(input stim_row_t row);
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= row.req;
    in_ch.value     <= row.val;
    in_ch.make_code <= row.mk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    keyboard_reply(row.req, row.val, row.mk);
    if (row.n_typed != FROM_MODEL) begin
      reply_bytes.delete();
      if (row.n_typed == ONE_BYTE) reply_bytes.push_back('{row.typed_code, row.typed_clr, 1'b1});
    end
    foreach (reply_bytes[k]) pending_bytes.push_back(reply_bytes[k]);
    items_accepted++;
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_for_host_bytes();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= kcp_pkg::REQ_CMD;
    in_ch.value     <= 8'h00;
    in_ch.make_code <= 8'h00;
    rst_n           <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[r]) offer(directed_rows[r]);
    wait_for_host_bytes();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_PAUSE_AT) wait_for_host_bytes();
      if (n == CALM_FROM) calm = 1'b1;
      offer(random_item());
    end
    wait_for_host_bytes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // host side: random back-pressure plus one long hold to fill the block
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && items_accepted >= LONG_HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) repeat (60) @(posedge clk);
        else repeat ($urandom_range(1, 20)) @(posedge clk);
        if ($urandom_range(0, 3) != 0) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    host_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected item: out_byte %h clear_first %b last %b",
               out_ch.out_byte, out_ch.clear_first, out_ch.last);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.out_byte !== want.code) begin
          $error("out_byte expected %h actual %h", want.code, out_ch.out_byte);
          fail_count++;
        end
        if (out_ch.clear_first !== want.clr) begin
          $error("clear_first expected %b actual %b", want.clr, out_ch.clear_first);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last expected %b actual %b", want.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
design/kcp_pkg.sv
design/kcp_ifs.sv
design/kcp_front.sv
design/kcp_queue.sv
design/kcp_back.sv
design/keyboard_command_processor.sv
test/testbench.sv
